// File: hw/rtl/ilfe_pkg.sv
// shared types and constants of the ising local field engine
package ilfe_pkg;

  // field widths of one input transaction
  localparam int OP_W  = 3;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int WIN_W = 16;

  // widths of state and results
  localparam int CNT_W = 7;
  localparam int OFS_W = 32;
  localparam int FLD_W = 24;
  localparam int RES_W = 40;

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // spin count after reset, before clamping to the built size
  localparam int SPIN_COUNT_RESET = 64;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_COUPLING = 3'd0,
    OP_WR_BIAS     = 3'd1,
    OP_WR_SPIN     = 3'd2,
    OP_INIT_FIELDS = 3'd3,
    OP_DELTA       = 3'd4,
    OP_FLIP        = 3'd5,
    OP_ENERGY      = 3'd6,
    OP_RD_FIELD    = 3'd7
  } op_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_OFFSET = 1'd1;

  // status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

endpackage

// File: hw/rtl/ilfe_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ilfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/ising_local_field_engine.sv
// ising local field engine: top level with sequencer, memories and datapath
//
// One input transaction is one operation on a dense Ising model held in
// memories: couplings and biases in signed Q8.8, single-bit spins and
// saturating local fields in signed Q16.8. Items are handled one at a time
// and every item returns one result transaction. A delta or a flip walks
// one coupling row, one entry per cycle from the coupling memory, over the
// n spins in use; a flip then also writes the toggled spin. Init fields and
// total energy walk the whole n by n matrix through the same read port. A
// result waits in an output register, so the next item is taken while it
// is still unclaimed. The spin and field stores come out of reset cleared
// through per-entry valid bits; couplings and biases must be written before
// they are used.
module ising_local_field_engine #(
  parameter int MAX_SPINS   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // operation, row_index, col_index, weight_value, spin_value
  input  logic [ilfe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_value, spin_after, status, zero padding
  output logic [ilfe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [ilfe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ilfe_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import ilfe_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SPINS);
  localparam int DEPTH  = 2 ** IDX_W;
  localparam int CMP_W  = (IDX_W > CNT_W ? IDX_W : CNT_W) + 1;
  localparam int SUM_W  = WEIGHT_BITS + 2 * IDX_W;
  localparam int ACC_W  = (SUM_W > OFS_W ? SUM_W : OFS_W) + 2;
  localparam int WIDE_W = ((ACC_W + 1) > RES_W ? (ACC_W + 1) : RES_W) + 1;
  localparam int WSAT_W = (WEIGHT_BITS > WIN_W ? WEIGHT_BITS : WIN_W) + 1;
  localparam int PAD_W  = OUT_TDATA_W - RES_W - 2;

  localparam logic signed [WIDE_W-1:0] RES_HI = WIDE_W'((64'sd1 <<< (RES_W - 1)) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] RES_LO = ~RES_HI;
  localparam logic signed [ACC_W-1:0]  FLD_HI = ACC_W'((64'sd1 <<< (FLD_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0]  FLD_LO = ~FLD_HI;
  localparam logic signed [WSAT_W-1:0] W_HI   =
    WSAT_W'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [WSAT_W-1:0] W_LO   = ~W_HI;
  localparam logic [CNT_W-1:0] CNT_RST =
    (MAX_SPINS < SPIN_COUNT_RESET) ? CNT_W'(MAX_SPINS) : CNT_W'(SPIN_COUNT_RESET);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SWEEP, ST_DRAIN, ST_FLIPW, ST_FIN, ST_RESP
  } state_e;

  state_e state_q;

  // configuration registers
  logic [CNT_W-1:0]        spin_count_q;
  logic signed [OFS_W-1:0] offset_q;
  logic [CNT_W-1:0]        cfg_cnt;

  // captured item
  op_e                           op_q;
  logic [ROW_W-1:0]              row_q;
  logic [COL_W-1:0]              col_q;
  logic signed [WEIGHT_BITS-1:0] w_q;
  logic                          sv_q;

  // input unpacking and weight saturation
  op_e                           in_op;
  logic signed [WIN_W-1:0]       in_w;
  logic signed [WSAT_W-1:0]      in_w_ext;
  logic signed [WEIGHT_BITS-1:0] in_w_sat;

  // sweep counters and first pipeline stage
  logic [IDX_W-1:0] i_q, j_q, i1_q, j1_q;
  logic             v1_q, start_q;
  logic             sk_q, si_q;
  logic signed [ACC_W-1:0] acc_q, acc_n;

  // memory ports
  logic                          coup_we, bias_we, spin_we, fld_we;
  logic [2*IDX_W-1:0]            coup_waddr, coup_raddr;
  logic [IDX_W-1:0]              bias_waddr, bias_raddr;
  logic [IDX_W-1:0]              spin_waddr, spin_raddr, fld_waddr, fld_raddr;
  logic                          spin_wdata, spin_rdata;
  logic signed [WEIGHT_BITS-1:0] coup_rdata, bias_rdata;
  logic signed [FLD_W-1:0]       fld_wdata, fld_rdata;

  // valid bits of the spin and field stores
  logic [DEPTH-1:0] spin_vld_q, fld_vld_q;
  logic             spin_rv_q, fld_rv_q;

  // decode and datapath signals
  logic                    row_ok, col_ok, err, single_row, sweep_op;
  logic                    last_j, last_i, diag, upper;
  logic [IDX_W-1:0]        row_a, col_a;
  logic                    spin_bit;
  logic signed [FLD_W-1:0] fld_rd;
  logic signed [ACC_W-1:0] jx, hx, term_j, fsum, fld_src;
  logic signed [WIDE_W-1:0] res_w, res_sat;
  logic [RES_W-1:0]        res_out;
  logic                    m_valid_q;
  logic [OUT_TDATA_W-1:0]  m_data_q;

  // unpack the input transaction
  assign in_op    = op_e'(s_axis_tdata[OP_W-1:0]);
  assign in_w     = s_axis_tdata[OP_W+ROW_W+COL_W +: WIN_W];
  assign in_w_ext = WSAT_W'(in_w);

  always_comb begin
    if (in_w_ext > W_HI) begin
      in_w_sat = W_HI[WEIGHT_BITS-1:0];
    end else if (in_w_ext < W_LO) begin
      in_w_sat = W_LO[WEIGHT_BITS-1:0];
    end else begin
      in_w_sat = in_w_ext[WEIGHT_BITS-1:0];
    end
  end

  // spin count clamped to one and to the built size
  always_comb begin
    cfg_cnt = cfg_data_i[CNT_W-1:0];
    if (cfg_cnt == '0) begin
      cfg_cnt = CNT_W'(1);
    end else if (int'(cfg_cnt) > MAX_SPINS) begin
      cfg_cnt = CNT_W'(MAX_SPINS);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_count_q <= CNT_RST;
      offset_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPIN_COUNT:    spin_count_q <= cfg_cnt;
        CFG_ENERGY_OFFSET: offset_q     <= cfg_data_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= in_op;
      row_q <= s_axis_tdata[OP_W +: ROW_W];
      col_q <= s_axis_tdata[OP_W+ROW_W +: COL_W];
      w_q   <= in_w_sat;
      sv_q  <= s_axis_tdata[OP_W+ROW_W+COL_W+WIN_W];
    end
  end

  // decode of the captured item
  assign row_a      = IDX_W'(row_q);
  assign col_a      = IDX_W'(col_q);
  assign row_ok     = CMP_W'(row_q) < CMP_W'(spin_count_q);
  assign col_ok     = CMP_W'(col_q) < CMP_W'(spin_count_q);
  assign single_row = (op_q == OP_DELTA) || (op_q == OP_FLIP);
  assign sweep_op   = single_row || (op_q == OP_INIT_FIELDS) || (op_q == OP_ENERGY);
  assign last_j     = CMP_W'(j_q) == CMP_W'(spin_count_q) - CMP_W'(1);
  assign last_i     = CMP_W'(i_q) == CMP_W'(spin_count_q) - CMP_W'(1);

  always_comb begin
    case (op_q)
      OP_WR_COUPLING:             err = !(row_ok && col_ok);
      OP_INIT_FIELDS, OP_ENERGY:  err = 1'b0;
      default:                    err = !row_ok;
    endcase
  end

  // read data of the spin and field stores, cleared entries read as zero
  assign spin_bit = spin_rdata & spin_rv_q;
  assign fld_rd   = fld_rv_q ? fld_rdata : '0;

  // stage one: accumulate the row sum, the energy or the field update
  assign diag   = i1_q == j1_q;
  assign upper  = j1_q > i1_q;
  assign jx     = ACC_W'(coup_rdata);
  assign hx     = ACC_W'(bias_rdata);
  assign term_j = spin_bit ? jx : -jx;
  assign fsum   = ACC_W'(fld_rd) + (sk_q ? -(jx <<< 1) : (jx <<< 1));

  always_comb begin
    acc_n = acc_q;
    case (op_q)
      OP_INIT_FIELDS, OP_DELTA: begin
        acc_n = ((j1_q == '0) ? hx : acc_q) + (diag ? '0 : term_j);
      end
      OP_ENERGY: begin
        if (diag) begin
          acc_n = acc_q + (spin_bit ? hx : -hx);
        end else if (upper) begin
          acc_n = acc_q + ((spin_bit == si_q) ? jx : -jx);
        end
      end
      default: ;
    endcase
  end

  // field saturation
  always_comb begin
    fld_src = (op_q == OP_FLIP) ? fsum : acc_n;
    if (fld_src > FLD_HI) begin
      fld_wdata = FLD_HI[FLD_W-1:0];
    end else if (fld_src < FLD_LO) begin
      fld_wdata = FLD_LO[FLD_W-1:0];
    end else begin
      fld_wdata = fld_src[FLD_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    coup_we    = (state_q == ST_DECODE) && (op_q == OP_WR_COUPLING) && !err;
    coup_waddr = {row_a, col_a};
    coup_raddr = {i_q, j_q};
    bias_we    = (state_q == ST_DECODE) && (op_q == OP_WR_BIAS) && !err;
    bias_waddr = row_a;
    bias_raddr = i_q;
    spin_waddr = row_a;
    spin_we    = 1'b0;
    spin_wdata = sv_q;
    if ((state_q == ST_DECODE) && (op_q == OP_WR_SPIN) && !err) begin
      spin_we = 1'b1;
    end else if (state_q == ST_FLIPW) begin
      spin_we    = 1'b1;
      spin_wdata = !sk_q;
    end
    spin_raddr = (state_q == ST_SWEEP) ? j_q : row_a;
    fld_raddr  = (state_q == ST_SWEEP) ? j_q : row_a;
    fld_we     = v1_q && (((op_q == OP_FLIP) && !diag) ||
                          ((op_q == OP_INIT_FIELDS) && (CMP_W'(j1_q) ==
                            CMP_W'(spin_count_q) - CMP_W'(1))));
    fld_waddr  = (op_q == OP_FLIP) ? j1_q : i1_q;
  end

  // memories
  ilfe_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH * DEPTH)) u_coup_ram (
    .clk_i   (clk_i),
    .we_i    (coup_we),
    .waddr_i (coup_waddr),
    .wdata_i (w_q),
    .raddr_i (coup_raddr),
    .rdata_o (coup_rdata)
  );

  ilfe_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bias_we),
    .waddr_i (bias_waddr),
    .wdata_i (w_q),
    .raddr_i (bias_raddr),
    .rdata_o (bias_rdata)
  );

  ilfe_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_spin_ram (
    .clk_i   (clk_i),
    .we_i    (spin_we),
    .waddr_i (spin_waddr),
    .wdata_i (spin_wdata),
    .raddr_i (spin_raddr),
    .rdata_o (spin_rdata)
  );

  ilfe_ram #(.WIDTH(FLD_W), .DEPTH(DEPTH)) u_fld_ram (
    .clk_i   (clk_i),
    .we_i    (fld_we),
    .waddr_i (fld_waddr),
    .wdata_i (fld_wdata),
    .raddr_i (fld_raddr),
    .rdata_o (fld_rdata)
  );

  // valid bits, read alongside the memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_vld_q <= '0;
      fld_vld_q  <= '0;
      spin_rv_q  <= 1'b0;
      fld_rv_q   <= 1'b0;
    end else begin
      if (spin_we) begin
        spin_vld_q[spin_waddr] <= 1'b1;
      end
      if (fld_we) begin
        fld_vld_q[fld_waddr] <= 1'b1;
      end
      spin_rv_q <= spin_vld_q[spin_raddr];
      fld_rv_q  <= fld_vld_q[fld_raddr];
    end
  end

  // stage one registers and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      start_q <= 1'b0;
    end else begin
      v1_q    <= state_q == ST_SWEEP;
      start_q <= state_q == ST_DECODE;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= i_q;
    j1_q <= j_q;
    if (state_q == ST_DECODE) begin
      acc_q <= ACC_W'(offset_q);
    end else if (v1_q) begin
      acc_q <= acc_n;
    end
    if (v1_q && diag && (op_q == OP_ENERGY)) begin
      si_q <= spin_bit;
    end
    if ((state_q == ST_SWEEP) && start_q) begin
      sk_q <= spin_bit;
    end
  end

  // result, saturated to the result width
  always_comb begin
    case (op_q)
      OP_DELTA:    res_w = sk_q ? -(WIDE_W'(acc_q) <<< 1) : (WIDE_W'(acc_q) <<< 1);
      OP_ENERGY:   res_w = WIDE_W'(acc_q);
      OP_RD_FIELD: res_w = WIDE_W'(fld_rd);
      default:     res_w = '0;
    endcase
    if (err) begin
      res_w = '0;
    end
    if (res_w > RES_HI) begin
      res_sat = RES_HI;
    end else if (res_w < RES_LO) begin
      res_sat = RES_LO;
    end else begin
      res_sat = res_w;
    end
    res_out = res_sat[RES_W-1:0];
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != ST_RESP)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          i_q <= single_row ? row_a : '0;
          j_q <= '0;
          if (err || !sweep_op) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (last_j) begin
            j_q <= '0;
            if (single_row || last_i) begin
              state_q <= ST_DRAIN;
            end else begin
              i_q <= i_q + IDX_W'(1);
            end
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= (op_q == OP_FLIP) ? ST_FLIPW : ST_FIN;
        end
        ST_FLIPW: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {{PAD_W{1'b0}}, (err ? STATUS_BAD_INDEX : STATUS_OK),
                          (row_ok ? spin_bit : 1'b0), res_out};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  // stage one only carries data while a sweep is running or draining
  a_stage_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
    else $error("stage one active outside a sweep");

  // a new transaction is only taken once the pipeline is empty
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !v1_q)
    else $error("input ready while sweep data in flight");

  // swept columns stay below the spin count
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (CMP_W'(j1_q) < CMP_W'(spin_count_q)))
    else $error("sweep column beyond spin count");

  // a delta or flip walks only the addressed row
  a_single_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && (op_q == OP_DELTA || op_q == OP_FLIP)) |-> (i1_q == row_a))
    else $error("single-row sweep left its row");

  // a flip toggles the spin store entry it addresses
  a_flip_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLIPW) |-> (spin_we && (spin_wdata == !sk_q)))
    else $error("flip did not write the toggled spin");
`endif

endmodule
